/* rtl/crsf_pkg.sv */
// Shared constants, types and the CRC-8 (poly 0xD5) step function for the
// frame receiver. No dependencies.
`default_nettype none

package crsf_pkg;

   localparam int FRAME_MAX     = 64;
   localparam int PAYLOAD_BYTES = 22;
   localparam int NUM_CH        = 16;
   localparam int CH_W          = 11;
   localparam int CH_IDX_W      = 4;
   localparam int POS_W         = $clog2(FRAME_MAX);
   localparam int FULL_W        = 9;
   localparam int PIDX_W        = $clog2(PAYLOAD_BYTES);
   localparam int STORE_W       = PAYLOAD_BYTES * 8;
   localparam int CSR_IDX_W     = 8;
   localparam int CSR_DATA_W    = 32;

   localparam logic [FULL_W-1:0] GUESS_LEN     = FULL_W'(5);
   localparam logic [FULL_W-1:0] FULL_MAX      = FULL_W'(FRAME_MAX);
   localparam logic [POS_W-1:0]  FIRST_PAYLOAD = POS_W'(3);
   localparam logic [7:0]        CRC_POLY      = 8'hD5;

   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_ADDRESS = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_TYPE    = CSR_IDX_W'(2);

   localparam logic [7:0] RST_ADDRESS = 8'd200;
   localparam logic [7:0] RST_TYPE    = 8'd22;

   typedef struct packed {
      logic [31:0] frame_timeout_us;
      logic [7:0]  accept_address;
      logic [7:0]  accept_type;
   } cfg_type;

   // frame end event handed to the result sequencer
   typedef struct packed {
      logic               valid;
      logic               crc_ok;
      logic               rc_accepted;
      logic [STORE_W-1:0] payload;
   } frame_evt_type;

   function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int i = 0; i < 8; i++) begin
         c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

/* rtl/crsf_if.sv */
// Valid/ready channel interfaces: received bytes, results and register writes.
// Depends on crsf_pkg.
`default_nettype none

interface crsf_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  rx_byte;
   logic [31:0] time_us;
   modport source (output valid, rx_byte, time_us, input ready);
   modport sink   (input valid, rx_byte, time_us, output ready);
endinterface

interface crsf_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          kind;
   logic                          crc_ok;
   logic                          rc_accepted;
   logic [crsf_pkg::CH_IDX_W-1:0] channel_index;
   logic [crsf_pkg::CH_W-1:0]     channel_value;
   logic                          last;
   modport source (output valid, kind, crc_ok, rc_accepted, channel_index,
                   channel_value, last, input ready);
   modport sink   (input valid, kind, crc_ok, rc_accepted, channel_index,
                   channel_value, last, output ready);
endinterface

interface crsf_csr_if;
   logic                            valid;
   logic                            ready;
   logic [crsf_pkg::CSR_IDX_W-1:0]  reg_index;
   logic [crsf_pkg::CSR_DATA_W-1:0] reg_data;
   modport source (output valid, reg_index, reg_data, input ready);
   modport sink   (input valid, reg_index, reg_data, output ready);
endinterface

`default_nettype wire

/* rtl/crsf_csr.sv */
// Configuration registers: timeout, accepted address and accepted type.
// Depends on crsf_pkg and crsf_if.
`default_nettype none

module crsf_csr (
   input  wire logic        clock,
   input  wire logic        reset,
   crsf_csr_if.sink         csr_ch,
   output crsf_pkg::cfg_type cfg
);
   import crsf_pkg::*;

   cfg_type cfg_ff, cfg_in;

   assign csr_ch.ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         case (csr_ch.reg_index)
            CSR_TIMEOUT: cfg_in.frame_timeout_us = csr_ch.reg_data;
            CSR_ADDRESS: cfg_in.accept_address   = csr_ch.reg_data[7:0];
            CSR_TYPE:    cfg_in.accept_type      = csr_ch.reg_data[7:0];
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_timeout_us <= '0;
         cfg_ff.accept_address   <= RST_ADDRESS;
         cfg_ff.accept_type      <= RST_TYPE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/crsf_deframer.sv */
// Per-byte frame tracking: timeout, position, header bytes, running CRC and
// payload store; flags the frame end. Depends on crsf_pkg and crsf_if.
`default_nettype none

module crsf_deframer (
   input  wire logic              clock,
   input  wire logic              reset,
   crsf_req_if.sink               req_ch,
   input  wire crsf_pkg::cfg_type cfg,
   input  wire logic              burst_free,
   output crsf_pkg::frame_evt_type evt
);
   import crsf_pkg::*;

   logic [POS_W-1:0] position_ff, position_in;
   logic [31:0]      start_time_ff, start_time_in;
   logic [7:0]       crc_ff, crc_in;
   logic [7:0]       address_ff, address_in;
   logic [7:0]       length_ff, length_in;
   logic [7:0]       type_ff, type_in;
   logic [7:0]       store_ff [PAYLOAD_BYTES];
   logic [7:0]       store_in [PAYLOAD_BYTES];

   logic [31:0]       elapsed;
   logic              timed_out;
   logic [POS_W-1:0]  pos_eff;
   logic [POS_W-1:0]  pay_off;
   logic [FULL_W-1:0] len_p2;
   logic [FULL_W-1:0] full;
   logic [FULL_W-1:0] pos_ext;
   logic              ignore;
   logic              frame_end;
   logic              accept;
   logic              crc_ok;

   assign elapsed   = req_ch.time_us - start_time_ff;
   assign timed_out = elapsed > cfg.frame_timeout_us;
   assign pos_eff   = timed_out ? '0 : position_ff;
   assign pos_ext   = FULL_W'(pos_eff);
   assign len_p2    = FULL_W'(length_ff) + FULL_W'(2);
   assign full      = (pos_eff < FIRST_PAYLOAD) ? GUESS_LEN :
                      ((len_p2 > FULL_MAX) ? FULL_MAX : len_p2);
   assign ignore    = pos_ext >= full;
   assign frame_end = !ignore && (pos_ext + FULL_W'(1) >= full);
   assign pay_off   = pos_eff - FIRST_PAYLOAD;

   // a frame-ending beat waits until the sequencer can take its burst
   assign req_ch.ready = !frame_end || burst_free;
   assign accept       = req_ch.valid && req_ch.ready;
   assign crc_ok       = crc_ff == req_ch.rx_byte;

   always_comb begin
      evt.valid       = accept && frame_end;
      evt.crc_ok      = crc_ok;
      evt.rc_accepted = crc_ok && (type_ff == cfg.accept_type) &&
                        (address_ff == cfg.accept_address);
      for (int i = 0; i < PAYLOAD_BYTES; i++) begin
         evt.payload[i*8 +: 8] = store_ff[i];
      end
   end

   always_comb begin
      position_in   = position_ff;
      start_time_in = start_time_ff;
      crc_in        = crc_ff;
      address_in    = address_ff;
      length_in     = length_ff;
      type_in       = type_ff;
      store_in      = store_ff;
      if (accept) begin
         position_in = pos_eff;
         if (pos_eff == '0) begin
            start_time_in = req_ch.time_us;
         end
         if (frame_end) begin
            position_in = '0;
            crc_in      = '0;
            address_in  = '0;
            length_in   = '0;
            type_in     = '0;
            for (int i = 0; i < PAYLOAD_BYTES; i++) begin
               store_in[i] = '0;
            end
         end else if (!ignore) begin
            position_in = pos_eff + POS_W'(1);
            if (pos_eff == POS_W'(0)) begin
               address_in = req_ch.rx_byte;
            end else if (pos_eff == POS_W'(1)) begin
               length_in = req_ch.rx_byte;
            end else if (pos_eff == POS_W'(2)) begin
               type_in = req_ch.rx_byte;
               crc_in  = crc8_step(8'h00, req_ch.rx_byte);
            end else begin
               crc_in = crc8_step(crc_ff, req_ch.rx_byte);
               for (int i = 0; i < PAYLOAD_BYTES; i++) begin
                  if (pay_off == POS_W'(i)) begin
                     store_in[i] = req_ch.rx_byte;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff   <= '0;
         start_time_ff <= '0;
         crc_ff        <= '0;
         address_ff    <= '0;
         length_ff     <= '0;
         type_ff       <= '0;
         for (int i = 0; i < PAYLOAD_BYTES; i++) begin
            store_ff[i] <= '0;
         end
      end else begin
         position_ff   <= position_in;
         start_time_ff <= start_time_in;
         crc_ff        <= crc_in;
         address_ff    <= address_in;
         length_ff     <= length_in;
         type_ff       <= type_in;
         store_ff      <= store_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/crsf_burst.sv */
// Result sequencer: registers a frame end event and plays out the status beat
// and, for an accepted frame, sixteen channel beats. Depends on crsf_pkg, crsf_if.
`default_nettype none

module crsf_burst (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire crsf_pkg::frame_evt_type evt,
   output logic                         burst_free,
   crsf_rsp_if.source                   rsp_ch
);
   import crsf_pkg::*;

   logic                busy_ff, busy_in;
   logic                kind_ff, kind_in;
   logic                ok_ff, ok_in;
   logic                acc_ff, acc_in;
   logic                last_ff, last_in;
   logic [CH_IDX_W-1:0] idx_ff, idx_in;
   logic [STORE_W-1:0]  snap_ff, snap_in;
   logic                take;

   assign burst_free           = !busy_ff;
   assign take                 = rsp_ch.valid && rsp_ch.ready;
   assign rsp_ch.valid         = busy_ff;
   assign rsp_ch.kind          = kind_ff;
   assign rsp_ch.crc_ok        = ok_ff;
   assign rsp_ch.rc_accepted   = acc_ff;
   assign rsp_ch.channel_index = idx_ff;
   assign rsp_ch.channel_value = kind_ff ? snap_ff[CH_W-1:0] : '0;
   assign rsp_ch.last          = last_ff;

   always_comb begin
      busy_in = busy_ff;
      kind_in = kind_ff;
      ok_in   = ok_ff;
      acc_in  = acc_ff;
      last_in = last_ff;
      idx_in  = idx_ff;
      snap_in = snap_ff;
      if (evt.valid) begin
         busy_in = 1'b1;
         kind_in = 1'b0;
         ok_in   = evt.crc_ok;
         acc_in  = evt.rc_accepted;
         last_in = !evt.rc_accepted;
         idx_in  = '0;
         snap_in = evt.payload;
      end else if (take) begin
         if (last_ff) begin
            busy_in = 1'b0;
         end else begin
            kind_in = 1'b1;
            ok_in   = 1'b1;
            acc_in  = 1'b1;
            // status beat -> channel 0 keeps the snapshot aligned
            if (kind_ff) begin
               idx_in  = idx_ff + CH_IDX_W'(1);
               snap_in = snap_ff >> CH_W;
            end else begin
               idx_in = '0;
            end
            last_in = kind_ff && (idx_ff == CH_IDX_W'(NUM_CH - 2));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      kind_ff <= kind_in;
      ok_ff   <= ok_in;
      acc_ff  <= acc_in;
      last_ff <= last_in;
      idx_ff  <= idx_in;
      snap_ff <= snap_in;
   end

endmodule

`default_nettype wire

/* rtl/crsf_frame_receiver_top.sv */
// Frame receiver: received bytes in, frame status and RC channel beats out.
// Depends on crsf_pkg, crsf_if, crsf_csr, crsf_deframer and crsf_burst.
//
// Channels: req_ch carries one received byte and its microsecond timestamp
// per beat; rsp_ch carries result beats; csr_ch writes the timeout (index 0),
// accepted address (1) and accepted type (2) registers, always ready.
// Throughput: one byte per cycle. A byte that ends a frame is held off while
// the result sequencer still plays out the previous frame's beats: a frame
// end yields one status beat, or a status beat plus sixteen channel beats
// when CRC, type and address all match, one beat per cycle while rsp_ch is
// ready. Since a frame is at least four bytes, a burst only stalls the link
// when the next frame end arrives before its playout is done.
// Latency: the status beat is valid the cycle after the frame-ending byte.
// When rsp_ch stalls, the current beat holds and input keeps flowing until a
// further frame end needs the sequencer.
// Reset: frame state, payload store and sequencer clear at once; registers
// return to timeout 0, address 200, type 22.
`default_nettype none

module crsf_frame_receiver_top (
   input  wire logic  clock,
   input  wire logic  reset,
   crsf_req_if.sink   req_ch,
   crsf_rsp_if.source rsp_ch,
   crsf_csr_if.sink   csr_ch
);
   import crsf_pkg::*;

   cfg_type       cfg;
   frame_evt_type evt;
   logic          burst_free;

   crsf_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   crsf_deframer u_deframer (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .cfg        (cfg),
      .burst_free (burst_free),
      .evt        (evt)
   );

   crsf_burst u_burst (
      .clock      (clock),
      .reset      (reset),
      .evt        (evt),
      .burst_free (burst_free),
      .rsp_ch     (rsp_ch)
   );

endmodule

`default_nettype wire

/* tb/crsf_frame_receiver_top_test.sv */
// Self-checking bench for crsf_frame_receiver_top: byte stream in, status and channel beats out,
// every result checked against an in-bench deframer model or a directed status beat.
// Depends on crsf_pkg, crsf_if and the RTL of crsf_frame_receiver_top.
`timescale 1ns / 1ps

module crsf_frame_receiver_top_test;
   import crsf_pkg::*;

   localparam int STALL_LIMIT     = 5000;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int SETTLE_CYCLES   = 40;
   localparam int PHASE_BYTES     = 75;

   typedef enum logic [1:0] {CRC_LIT, CRC_GOOD, CRC_BAD} crc_pick_type;
   typedef enum logic [1:0] {CHK_PRED, CHK_NONE, CHK_STATUS} row_check_type;
   typedef enum logic [1:0] {BRK_NOISE, BRK_TRUNCATED, BRK_SHORT_LEN} broken_kind_type;

   typedef struct packed {
      logic                kind;
      logic                crc_ok;
      logic                rc_accepted;
      logic [CH_IDX_W-1:0] channel_index;
      logic [CH_W-1:0]     channel_value;
      logic                last;
   } rsp_beat_type;

   typedef struct packed {
      logic [7:0]    data;
      logic [31:0]   stamp;
      crc_pick_type  pick;
      row_check_type chk;
      rsp_beat_type  status;
   } stim_row_type;

   localparam rsp_beat_type NO_BEAT = '0;

   logic clock;
   logic reset;

   crsf_req_if req_ch();
   crsf_rsp_if rsp_ch();
   crsf_csr_if csr_ch();

   crsf_frame_receiver_top DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // deframer model state
   cfg_type      shadow_cfg;
   int unsigned  fr_pos;
   logic [31:0]  fr_start;
   logic [7:0]   fr_crc;
   logic [7:0]   fr_addr;
   logic [7:0]   fr_len;
   logic [7:0]   fr_type;
   logic [7:0]   fr_payload [PAYLOAD_BYTES];
   rsp_beat_type pending_beats [$];

   logic [31:0] link_time;
   int          req_idle_pct;
   int          rsp_idle_pct;
   bit          hold_off_req = 1'b0;
   int          stall_cycles = 0;
   int          mismatches = 0;
   int unsigned bytes_sent = 0;
   int unsigned frames_sent = 0;
   int unsigned broken_seqs = 0;
   int unsigned status_beats = 0;
   int unsigned channel_beats = 0;

   // short frames at reset settings (timeout 0: a frame keeps one timestamp)
   stim_row_type directed_rows [26] = '{
      // accepted frame, empty payload: all channels read zero
      '{8'hC8, 32'd0, CRC_LIT, CHK_NONE, NO_BEAT},
      '{8'h02, 32'd0, CRC_LIT, CHK_NONE, NO_BEAT},
      '{8'h16, 32'd0, CRC_LIT, CHK_NONE, NO_BEAT},
      '{8'h00, 32'd0, CRC_GOOD, CHK_PRED, NO_BEAT},
      // corrupted CRC
      '{8'hC8, 32'd0, CRC_LIT, CHK_NONE, NO_BEAT},
      '{8'h02, 32'd0, CRC_LIT, CHK_NONE, NO_BEAT},
      '{8'h16, 32'd0, CRC_LIT, CHK_NONE, NO_BEAT},
      '{8'h00, 32'd0, CRC_BAD, CHK_STATUS, '{1'b0, 1'b0, 1'b0, 4'd0, 11'd0, 1'b1}},
      // good CRC, foreign address
      '{8'h00, 32'd0, CRC_LIT, CHK_NONE, NO_BEAT},
      '{8'h02, 32'd0, CRC_LIT, CHK_NONE, NO_BEAT},
      '{8'h16, 32'd0, CRC_LIT, CHK_NONE, NO_BEAT},
      '{8'h00, 32'd0, CRC_GOOD, CHK_STATUS, '{1'b0, 1'b1, 1'b0, 4'd0, 11'd0, 1'b1}},
      // length 0 locks the frame; trailing byte ignored
      '{8'hFF, 32'hFFFF_FFFF, CRC_LIT, CHK_NONE, NO_BEAT},
      '{8'h00, 32'hFFFF_FFFF, CRC_LIT, CHK_NONE, NO_BEAT},
      '{8'hFF, 32'hFFFF_FFFF, CRC_LIT, CHK_NONE, NO_BEAT},
      '{8'h55, 32'hFFFF_FFFF, CRC_LIT, CHK_NONE, NO_BEAT},
      // time wraps to 0: gap of 1 restarts; this frame is then aborted
      '{8'hC8, 32'd0, CRC_LIT, CHK_NONE, NO_BEAT},
      '{8'h06, 32'd0, CRC_LIT, CHK_NONE, NO_BEAT},
      '{8'h16, 32'd0, CRC_LIT, CHK_NONE, NO_BEAT},
      '{8'hAA, 32'd0, CRC_LIT, CHK_NONE, NO_BEAT},
      '{8'hBB, 32'd0, CRC_LIT, CHK_NONE, NO_BEAT},
      // one payload byte; store byte 1 still holds the aborted frame's data
      '{8'hC8, 32'd1, CRC_LIT, CHK_NONE, NO_BEAT},
      '{8'h03, 32'd1, CRC_LIT, CHK_NONE, NO_BEAT},
      '{8'h16, 32'd1, CRC_LIT, CHK_NONE, NO_BEAT},
      '{8'h7F, 32'd1, CRC_LIT, CHK_NONE, NO_BEAT},
      '{8'h00, 32'd1, CRC_GOOD, CHK_PRED, NO_BEAT}
   };

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [7:0] crc8_dvb_s2(input logic [7:0] crc, input logic [7:0] d);
      logic [7:0] r;
      r = crc ^ d;
      repeat (8) r = {r[6:0], 1'b0} ^ (r[7] ? CRC_POLY : 8'h00);
      return r;
   endfunction

   function automatic void clear_frame_state();
      fr_pos  = 0;
      fr_crc  = '0;
      fr_addr = '0;
      fr_len  = '0;
      fr_type = '0;
      foreach (fr_payload[i]) fr_payload[i] = '0;
   endfunction

   // advance the deframer by one byte; queue the beats it causes when record is set
   task automatic deframe_byte(input logic [7:0] b, input logic [31:0] now, input bit record);
      logic [31:0]        gap;
      int unsigned        full;
      logic               ok;
      logic               acc;
      logic [STORE_W-1:0] store;
      rsp_beat_type       beat;
      gap = now - fr_start;
      if (gap > shadow_cfg.frame_timeout_us) fr_pos = 0;
      if (fr_pos == 0) fr_start = now;
      if (fr_pos < FIRST_PAYLOAD) full = GUESS_LEN;
      else full = (int'(fr_len) + 2 > FRAME_MAX) ? FRAME_MAX : int'(fr_len) + 2;
      if (fr_pos >= full) return;
      if (fr_pos + 1 >= full) begin
         ok  = (fr_crc == b);
         acc = ok && fr_type == shadow_cfg.accept_type && fr_addr == shadow_cfg.accept_address;
         foreach (fr_payload[i]) store[8*i +: 8] = fr_payload[i];
         if (record) begin
            beat = '{kind: 1'b0, crc_ok: ok, rc_accepted: acc, channel_index: '0,
                     channel_value: '0, last: !acc};
            pending_beats.push_back(beat);
            if (acc) begin
               for (int ch = 0; ch < NUM_CH; ch++) begin
                  beat = '{kind: 1'b1, crc_ok: 1'b1, rc_accepted: 1'b1,
                           channel_index: CH_IDX_W'(ch), channel_value: store[CH_W*ch +: CH_W],
                           last: (ch == NUM_CH - 1)};
                  pending_beats.push_back(beat);
               end
            end
         end
         clear_frame_state();
         return;
      end
      case (fr_pos)
         0: fr_addr = b;
         1: fr_len = b;
         2: begin
            fr_type = b;
            fr_crc  = crc8_dvb_s2(8'h00, b);
         end
         default: begin
            fr_crc = crc8_dvb_s2(fr_crc, b);
            if (fr_pos - FIRST_PAYLOAD < PAYLOAD_BYTES) fr_payload[fr_pos - FIRST_PAYLOAD] = b;
         end
      endcase
      fr_pos++;
   endtask

   task automatic report_mismatch(input string msg);
      mismatches++;
      $display("%0t: mismatch: %s", $time, msg);
   endtask

   task automatic check_field(input string name, input logic [10:0] got, input logic [10:0] want);
      if (got !== want)
         report_mismatch($sformatf("beat %0d %s got %0d want %0d",
                                   status_beats + channel_beats, name, got, want));
   endtask

   always @(posedge clock) begin : check_beats
      rsp_beat_type got;
      rsp_beat_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = '{rsp_ch.kind, rsp_ch.crc_ok, rsp_ch.rc_accepted, rsp_ch.channel_index,
                 rsp_ch.channel_value, rsp_ch.last};
         if (pending_beats.size() == 0) begin
            report_mismatch($sformatf("unexpected beat kind %0b index %0d value %0d",
                                      got.kind, got.channel_index, got.channel_value));
         end else begin
            want = pending_beats.pop_front();
            check_field("kind", 11'(got.kind), 11'(want.kind));
            check_field("crc_ok", 11'(got.crc_ok), 11'(want.crc_ok));
            check_field("rc_accepted", 11'(got.rc_accepted), 11'(want.rc_accepted));
            check_field("channel_index", 11'(got.channel_index), 11'(want.channel_index));
            check_field("channel_value", got.channel_value, want.channel_value);
            check_field("last", 11'(got.last), 11'(want.last));
            if (want.kind) channel_beats++;
            else status_beats++;
         end
      end
   end

   // result side backpressure; one long hold-off on request
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
   end

   initial begin
      while (stall_cycles < STALL_LIMIT) @(posedge clock);
      $display("no beat moved for %0d cycles, %0d results outstanding",
               STALL_LIMIT, pending_beats.size());
      $display("crsf_frame_receiver_top_test: FAIL");
      $finish;
   end

   task automatic offer_byte(input logic [7:0] b, input logic [31:0] t);
      while ($urandom_range(99) < req_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.rx_byte <= b;
      req_ch.time_us <= t;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic feed_byte(input logic [7:0] b, input logic [31:0] t);
      offer_byte(b, t);
      deframe_byte(b, t, 1'b1);
   endtask

   function automatic logic [7:0] payload_byte();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 15) return 8'h00;
      if (roll < 30) return 8'hFF;
      return 8'($urandom);
   endfunction

   // per-byte time step that keeps a whole frame inside the timeout
   function automatic int unsigned byte_step_max();
      logic [31:0] s;
      s = shadow_cfg.frame_timeout_us / FRAME_MAX;
      return (s > 1000) ? 1000 : s;
   endfunction

   task automatic send_frame();
      int unsigned len;
      int unsigned total;
      int unsigned step_max;
      int unsigned roll;
      logic [7:0]  b;
      roll = $urandom_range(99);
      if (roll < 40) len = PAYLOAD_BYTES + 2;
      else if (roll < 75) len = $urandom_range(PAYLOAD_BYTES + 1, 2);
      else if (roll < 90) len = $urandom_range(FRAME_MAX - 3, PAYLOAD_BYTES + 3);
      else len = $urandom_range(255, FRAME_MAX - 2);
      total = (len + 2 > FRAME_MAX) ? FRAME_MAX : len + 2;
      step_max = byte_step_max();
      for (int i = 0; i < total; i++) begin
         if (i > 0) link_time += $urandom_range(step_max);
         if (i == 0)
            b = ($urandom_range(99) < 85) ? shadow_cfg.accept_address : 8'($urandom);
         else if (i == 1)
            b = len[7:0];
         else if (i == 2)
            b = ($urandom_range(99) < 85) ? shadow_cfg.accept_type : 8'($urandom);
         else if (i == total - 1)
            b = ($urandom_range(99) < 85) ? fr_crc : 8'($urandom);
         else
            b = payload_byte();
         feed_byte(b, link_time);
      end
      frames_sent++;
      roll = $urandom_range(99);
      if (roll >= 80) link_time += $urandom;
      else if (roll >= 50) link_time += $urandom_range(5000);
   endtask

   // garbage, a cut-off frame or a length too short; then a gap that restarts the frame
   task automatic send_broken();
      int unsigned     n;
      int unsigned     step_max;
      broken_kind_type shape;
      logic [7:0]      b;
      step_max = byte_step_max();
      shape = broken_kind_type'($urandom_range(2));
      n = (shape == BRK_TRUNCATED) ? $urandom_range(8, 1) : $urandom_range(6, 3);
      for (int i = 0; i < n; i++) begin
         if (i > 0) link_time += $urandom_range(step_max);
         case (shape)
            BRK_TRUNCATED: begin
               if (i == 0) b = shadow_cfg.accept_address;
               else if (i == 1) b = 8'($urandom_range(255, 9));
               else if (i == 2) b = shadow_cfg.accept_type;
               else b = payload_byte();
            end
            BRK_SHORT_LEN: b = (i == 1) ? 8'($urandom_range(1)) : payload_byte();
            default: b = payload_byte();
         endcase
         feed_byte(b, link_time);
      end
      broken_seqs++;
      link_time += shadow_cfg.frame_timeout_us + 1 + $urandom_range(50);
   endtask

   task automatic run_traffic(input int unsigned quota, input bit with_noise);
      int unsigned stop_at;
      stop_at = bytes_sent + quota;
      while (bytes_sent < stop_at) begin
         if (with_noise && $urandom_range(99) < 25) send_broken();
         send_frame();
      end
   endtask

   task automatic await_csr();
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
   endtask

   task automatic apply_settings(input logic [31:0] timeout, input logic [7:0] addr,
                                 input logic [7:0] ftype);
      csr_ch.valid     <= 1'b1;
      csr_ch.reg_index <= CSR_TIMEOUT;
      csr_ch.reg_data  <= timeout;
      await_csr();
      shadow_cfg.frame_timeout_us = timeout;
      csr_ch.reg_index <= CSR_ADDRESS;
      csr_ch.reg_data  <= CSR_DATA_W'(addr);
      await_csr();
      shadow_cfg.accept_address = addr;
      csr_ch.reg_index <= CSR_TYPE;
      csr_ch.reg_data  <= CSR_DATA_W'(ftype);
      await_csr();
      shadow_cfg.accept_type = ftype;
      csr_ch.valid <= 1'b0;
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      while (pending_beats.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      stim_row_type row;
      logic [7:0]   b;
      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.rx_byte   <= '0;
      req_ch.time_us   <= '0;
      csr_ch.valid     <= 1'b0;
      csr_ch.reg_index <= '0;
      csr_ch.reg_data  <= '0;
      shadow_cfg = '{frame_timeout_us: 32'd0, accept_address: RST_ADDRESS,
                     accept_type: RST_TYPE};
      clear_frame_state();
      fr_start  = '0;
      link_time = '0;
      req_idle_pct = 23;
      rsp_idle_pct = 45;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < $size(directed_rows); i++) begin
         row = directed_rows[i];
         case (row.pick)
            CRC_GOOD: b = fr_crc;
            CRC_BAD:  b = ~fr_crc;
            default:  b = row.data;
         endcase
         offer_byte(b, row.stamp);
         deframe_byte(b, row.stamp, row.chk == CHK_PRED);
         if (row.chk == CHK_STATUS) pending_beats.push_back(row.status);
      end
      drain();

      // moderate timeout, zero address and type, time crossing the wrap
      apply_settings(32'd1000, 8'h00, 8'h00);
      link_time = 32'hFFFF_F000;
      run_traffic(PHASE_BYTES, 1'b1);
      drain();

      // timeout never fires: well-formed frames only
      req_idle_pct = 45;
      rsp_idle_pct = 23;
      apply_settings(32'hFFFF_FFFF, 8'hFF, 8'hFF);
      run_traffic(PHASE_BYTES, 1'b0);
      drain();

      // full rate, with one long result stall that backs up the input
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      apply_settings(32'd0, RST_ADDRESS, RST_TYPE);
      hold_off_req = 1'b1;
      run_traffic(PHASE_BYTES, 1'b1);
      drain();

      apply_settings(32'($urandom_range(100000, 1)), 8'($urandom), 8'($urandom));
      run_traffic(PHASE_BYTES, 1'b1);
      drain();

      $display("fed %0d bytes: %0d random frames, %0d broken sequences, four register settings",
               bytes_sent, frames_sent, broken_seqs);
      $display("checked %0d status beats and %0d channel beats, %0d mismatches",
               status_beats, channel_beats, mismatches);
      if (mismatches == 0)
         $display("crsf_frame_receiver_top_test: PASS");
      else
         $display("crsf_frame_receiver_top_test: FAIL");
      $finish;
   end

endmodule
